FILE: rtl/dpps_pkg.sv
package dpps_pkg;

	// input item kinds
	localparam logic ACT_ADD  = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// one queued process
	typedef struct packed {
		logic [7:0]        id;
		logic signed [7:0] prio;
		logic [7:0]        rtime;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// one result item
	typedef struct packed {
		logic              ok;
		logic [7:0]        process_id;
		logic signed [7:0] priority_after;
		logic [7:0]        remaining_after;
		logic              finished;
		logic              queue_empty;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FREE,
		ST_TICK,
		ST_INS,
		ST_HEAD,
		ST_WALK,
		ST_LINK,
		ST_LINK2,
		ST_RESP
	} state_t;

endpackage

FILE: rtl/dynamic_priority_process_scheduler.sv
// Priority ready queue with aging, one process list kept in a linked-list RAM.
// Input channel (in_valid / in_stall): action = add takes new_priority and
// run_time; action = tick runs the head process once. Each input item gives
// exactly one result item on the output channel (out_valid / out_stall).
// One item is worked at a time; in_stall is high while an item is in flight.
// Work per item: a refused add or a tick on an empty queue goes straight to
// the result; an add into an empty queue writes its slot, one ahead of the head
// first reads the head (an add first pops a slot from the free list once fresh
// slots are used up); a tick that finishes its process frees its slot; other
// inserts and requeues walk the list one entry per cycle, set by the single
// read port. The next item is taken on the edge where the result can first be
// taken, so a new item waits until the last result is in the output register.
// Reset empties the queue and restarts ids at zero; the RAM itself is not
// cleared, slots are handed out from a fill counter and then a free list.
// The result sits in an output register; if the receiver stalls, the block
// still accepts and works the next item and only waits when a second result
// is ready while the first is still stalled.
module dynamic_priority_process_scheduler import dpps_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              action,
	input  logic signed [7:0] new_priority,
	input  logic [7:0]        run_time,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              ok,
	output logic [7:0]        process_id,
	output logic signed [7:0] priority_after,
	output logic [7:0]        remaining_after,
	output logic              finished,
	output logic              queue_empty
);

	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int WORD_W = ENTRY_W + PTR_W;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
	localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

	state_t state_q, state_d;

	// control state
	logic [CNT_W-1:0] cnt_q;        // processes in the ready list
	logic [CNT_W-1:0] fill_q;       // slots ever handed out
	logic [PTR_W-1:0] head_q;       // head of the ready list
	logic [PTR_W-1:0] free_head_q;  // head of the free list
	logic [7:0]       next_id_q;

	// per-item working registers
	entry_t           ent_q;        // entry being inserted
	logic [PTR_W-1:0] slot_q;       // its RAM slot
	logic [PTR_W-1:0] prev_q;       // entry it goes behind
	entry_t           prev_ent_q;
	logic [PTR_W-1:0] cur_q;        // entry it goes in front of
	logic [CNT_W-1:0] left_q;       // entries from cur to the tail
	result_t          res_q;

	// RAM port signals
	logic              rd_en, wr_en;
	logic [PTR_W-1:0]  rd_addr, wr_addr;
	logic [WORD_W-1:0] rd_data, wr_data;
	entry_t            rd_ent;
	logic [PTR_W-1:0]  rd_next;

	logic              in_acc;
	logic              add_refused;
	logic              ob_load, ob_can_load;
	result_t           ob_res;

	// aged head on a tick
	entry_t            aged;
	logic              aged_fin;

	assign rd_ent  = entry_t'(rd_data[WORD_W-1:PTR_W]);
	assign rd_next = rd_data[PTR_W-1:0];

	assign in_stall    = (state_q != ST_IDLE);
	assign in_acc      = in_valid && !in_stall;
	assign add_refused = (cnt_q == DEPTH_C) || (run_time == 8'd0);

	always_comb begin
		aged       = rd_ent;
		aged.prio  = (rd_ent.prio == -8'sd128) ? rd_ent.prio : rd_ent.prio - 8'sd1;
		aged.rtime = (rd_ent.rtime != 8'd0) ? rd_ent.rtime - 8'd1 : rd_ent.rtime;
		aged_fin   = (aged.rtime == 8'd0);
	end

	always_comb begin
		ob_res             = res_q;
		ob_res.queue_empty = (cnt_q == '0);
	end

	dpps_mem #(
		.DEPTH  (QUEUE_DEPTH),
		.ADDR_W (PTR_W),
		.DATA_W (WORD_W)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	dpps_obuf u_obuf (
		.clk             (clk),
		.arst_n          (arst_n),
		.load            (ob_load),
		.res             (ob_res),
		.can_load        (ob_can_load),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.ok              (ok),
		.process_id      (process_id),
		.priority_after  (priority_after),
		.remaining_after (remaining_after),
		.finished        (finished),
		.queue_empty     (queue_empty)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and RAM control. Reads and writes never hit the same slot in
	// one cycle: every write happens after all reads of an item are done.
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = head_q;
		wr_en   = 1'b0;
		wr_addr = slot_q;
		wr_data = {ent_q, cur_q};
		ob_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (action == ACT_ADD) begin
						if (add_refused) begin
							state_d = ST_RESP;
						end else if (fill_q != DEPTH_C) begin
							state_d = ST_INS;
						end else begin
							rd_en   = 1'b1;
							rd_addr = free_head_q;
							state_d = ST_FREE;
						end
					end else if (cnt_q == '0) begin
						state_d = ST_RESP;
					end else begin
						rd_en   = 1'b1;
						rd_addr = head_q;
						state_d = ST_TICK;
					end
				end
			end
			ST_FREE: begin
				state_d = ST_INS;
			end
			ST_TICK: begin
				if (aged_fin) begin
					// finished: slot goes onto the free list
					wr_en   = 1'b1;
					wr_addr = head_q;
					wr_data = {rd_ent, free_head_q};
					state_d = ST_RESP;
				end else begin
					state_d = ST_INS;
				end
			end
			ST_INS: begin
				if (cnt_q == '0) begin
					wr_en   = 1'b1;
					wr_addr = slot_q;
					wr_data = {ent_q, cur_q};
					state_d = ST_RESP;
				end else begin
					rd_en   = 1'b1;
					rd_addr = head_q;
					state_d = ST_HEAD;
				end
			end
			ST_HEAD: begin
				if (rd_ent.prio < ent_q.prio) begin
					// new head
					wr_en   = 1'b1;
					wr_addr = slot_q;
					wr_data = {ent_q, head_q};
					state_d = ST_RESP;
				end else if (cnt_q == ONE_C) begin
					state_d = ST_LINK;
				end else begin
					rd_en   = 1'b1;
					rd_addr = rd_next;
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (ent_q.prio < rd_ent.prio) begin
					if (left_q == ONE_C) begin
						state_d = ST_LINK;
					end else begin
						rd_en   = 1'b1;
						rd_addr = rd_next;
					end
				end else begin
					state_d = ST_LINK;
				end
			end
			ST_LINK: begin
				wr_en   = 1'b1;
				wr_addr = slot_q;
				wr_data = {ent_q, cur_q};
				state_d = ST_LINK2;
			end
			ST_LINK2: begin
				wr_en   = 1'b1;
				wr_addr = prev_q;
				wr_data = {prev_ent_q, slot_q};
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (ob_can_load) begin
					ob_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// list bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			fill_q      <= '0;
			head_q      <= '0;
			free_head_q <= '0;
			next_id_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && action == ACT_ADD && !add_refused) begin
						next_id_q <= next_id_q + 8'd1;
						if (fill_q != DEPTH_C) begin
							fill_q <= fill_q + ONE_C;
						end
					end
				end
				ST_FREE: begin
					free_head_q <= rd_next;
				end
				ST_TICK: begin
					head_q <= rd_next;
					cnt_q  <= cnt_q - ONE_C;
					if (aged_fin) begin
						free_head_q <= head_q;
					end
				end
				ST_INS: begin
					if (cnt_q == '0) begin
						head_q <= slot_q;
						cnt_q  <= cnt_q + ONE_C;
					end
				end
				ST_HEAD: begin
					if (rd_ent.prio < ent_q.prio) begin
						head_q <= slot_q;
						cnt_q  <= cnt_q + ONE_C;
					end
				end
				ST_LINK2: begin
					cnt_q <= cnt_q + ONE_C;
				end
				default: begin
				end
			endcase
		end
	end

	// working registers and result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (action == ACT_ADD && !add_refused) begin
						ent_q  <= '{id: next_id_q, prio: new_priority, rtime: run_time};
						slot_q <= fill_q[PTR_W-1:0];
						res_q  <= '{ok: 1'b1, process_id: next_id_q,
							priority_after: new_priority, remaining_after: run_time,
							finished: 1'b0, queue_empty: 1'b0};
					end else begin
						res_q <= '0;
					end
				end
			end
			ST_FREE: begin
				slot_q <= free_head_q;
			end
			ST_TICK: begin
				ent_q  <= aged;
				slot_q <= head_q;
				res_q  <= '{ok: 1'b1, process_id: aged.id, priority_after: aged.prio,
					remaining_after: aged.rtime, finished: aged_fin, queue_empty: 1'b0};
			end
			ST_HEAD: begin
				prev_q     <= head_q;
				prev_ent_q <= rd_ent;
				cur_q      <= rd_next;
				left_q     <= cnt_q - ONE_C;
			end
			ST_WALK: begin
				if (ent_q.prio < rd_ent.prio) begin
					prev_q     <= cur_q;
					prev_ent_q <= rd_ent;
					cur_q      <= rd_next;
					left_q     <= left_q - ONE_C;
				end
			end
			default: begin
			end
		endcase
	end

	// live entries never outnumber slots handed out
	a_cnt_fill: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= fill_q && fill_q <= DEPTH_C)
		else $error("ready count exceeds allocated slots");

	// an accepted item always starts work
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != ST_IDLE)
		else $error("accepted item dropped");

	// the list walk never runs past the tail
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> left_q != '0)
		else $error("list walk beyond tail");

	// a free-list pop only happens while a free slot exists
	a_free_pop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FREE |-> cnt_q < fill_q)
		else $error("free list pop with no free slot");

	// a finished result shows up right after it is handed over
	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		ob_load |=> out_valid)
		else $error("result lost at output register");

endmodule

FILE: rtl/dpps_mem.sv
module dpps_mem import dpps_pkg::*; #(
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4,
	parameter int DATA_W = 28
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read; read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/dpps_obuf.sv
module dpps_obuf import dpps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  result_t           res,
	output logic              can_load,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              ok,
	output logic [7:0]        process_id,
	output logic signed [7:0] priority_after,
	output logic [7:0]        remaining_after,
	output logic              finished,
	output logic              queue_empty
);

	logic    valid_q;
	result_t res_q;

	assign can_load = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load) begin
			res_q <= res;
		end
	end

	assign out_valid       = valid_q;
	assign ok              = res_q.ok;
	assign process_id      = res_q.process_id;
	assign priority_after  = res_q.priority_after;
	assign remaining_after = res_q.remaining_after;
	assign finished        = res_q.finished;
	assign queue_empty     = res_q.queue_empty;

endmodule

FILE: tb/dpps_schedule_checker.sv
module dpps_schedule_checker import dpps_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              action,
	input  logic signed [7:0] new_priority,
	input  logic [7:0]        run_time,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic              ok,
	input  logic [7:0]        process_id,
	input  logic signed [7:0] priority_after,
	input  logic [7:0]        remaining_after,
	input  logic              finished,
	input  logic              queue_empty,
	output int                mismatches,
	output int                awaited
);
	timeunit 1ns;
	timeprecision 1ps;

	// shadow of the ready queue, head at index 0
	entry_t     ready_list [QUEUE_DEPTH];
	int         ready_len;
	logic [7:0] id_next;
	result_t    predicted_outcomes [$];
	result_t    want;

	// head goes first on a strictly higher priority; otherwise the walk
	// starts behind the head and stops at the first entry not higher
	function automatic void ready_insert(entry_t e);
		int pos;
		int k;
		if (ready_len == 0 || $signed(ready_list[0].prio) < $signed(e.prio)) begin
			pos = 0;
		end else begin
			pos = 1;
			while (pos < ready_len && $signed(e.prio) < $signed(ready_list[pos].prio))
				pos++;
		end
		for (k = ready_len; k > pos; k--)
			ready_list[k] = ready_list[k - 1];
		ready_list[pos] = e;
		ready_len++;
	endfunction

	function automatic result_t schedule_step(logic act, logic signed [7:0] pr,
			logic [7:0] rt);
		result_t r;
		entry_t  h;
		int      k;
		r = '0;
		if (act == ACT_ADD) begin
			if (ready_len < QUEUE_DEPTH && rt != 8'd0) begin
				h.id    = id_next;
				h.prio  = pr;
				h.rtime = rt;
				id_next = id_next + 8'd1;
				ready_insert(h);
				r.ok              = 1'b1;
				r.process_id      = h.id;
				r.priority_after  = h.prio;
				r.remaining_after = h.rtime;
			end
		end else if (ready_len > 0) begin
			h = ready_list[0];
			for (k = 1; k < ready_len; k++)
				ready_list[k - 1] = ready_list[k];
			ready_len--;
			// aging saturates at the most negative priority
			if (h.prio != 8'h80)
				h.prio = h.prio - 8'sd1;
			if (h.rtime != 8'd0)
				h.rtime = h.rtime - 8'd1;
			r.ok              = 1'b1;
			r.process_id      = h.id;
			r.priority_after  = h.prio;
			r.remaining_after = h.rtime;
			if (h.rtime == 8'd0)
				r.finished = 1'b1;
			else
				ready_insert(h);
		end
		r.queue_empty = (ready_len == 0);
		return r;
	endfunction

	function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t ns: %s mismatch, expected 0x%02h, got 0x%02h",
				$time, name, exp_v, got_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_len  = 0;
			id_next    = 8'd0;
			mismatches = 0;
			predicted_outcomes.delete();
		end else begin
			if (in_valid && !in_stall)
				predicted_outcomes.push_back(schedule_step(action, new_priority, run_time));
			if (out_valid && !out_stall) begin
				if (predicted_outcomes.size() == 0) begin
					$display("%0t ns: unexpected result, expected none, got id 0x%02h ok %b",
						$time, process_id, ok);
					mismatches++;
				end else begin
					want = predicted_outcomes.pop_front();
					check_field("ok", want.ok, ok);
					check_field("process_id", want.process_id, process_id);
					check_field("priority_after", want.priority_after, priority_after);
					check_field("remaining_after", want.remaining_after, remaining_after);
					check_field("finished", want.finished, finished);
					check_field("queue_empty", want.queue_empty, queue_empty);
				end
			end
		end
		awaited = predicted_outcomes.size();
	end

endmodule

FILE: tb/dynamic_priority_process_scheduler_test.sv
module dynamic_priority_process_scheduler_test import dpps_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUEUE_DEPTH = 16;
	// longest walk through the list plus response and margin
	localparam int TAIL_CYCLES = QUEUE_DEPTH + 12;
	// long enough that the output register and the next item both back up
	localparam int HOLD_CYCLES = 120;

	logic              clk             = 1'b0;
	logic              arst_n          = 1'b0;
	logic              in_valid        = 1'b0;
	logic              in_stall;
	logic              action          = ACT_ADD;
	logic signed [7:0] new_priority    = '0;
	logic [7:0]        run_time        = '0;
	logic              out_valid;
	logic              out_stall       = 1'b0;
	logic              ok;
	logic [7:0]        process_id;
	logic signed [7:0] priority_after;
	logic [7:0]        remaining_after;
	logic              finished;
	logic              queue_empty;

	int  mismatches;
	int  awaited;
	int  send_idle_pct = 38;
	int  recv_idle_pct = 79;
	bit  hold_request  = 1'b0;
	int  adds_sent     = 0;
	int  ticks_sent    = 0;

	dynamic_priority_process_scheduler #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (.*);

	dpps_schedule_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) checker_i (.*);

	// 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Receiver: random stall each falling edge, or a long hold-off on request.
	// The hold-off is counted here so the sender keeps pushing meanwhile.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	// Offer one item; called at a falling edge, returns at the falling edge
	// after acceptance with valid still high so back-to-back items don't glitch.
	task automatic send_item(logic act, logic signed [7:0] pr, logic [7:0] rt);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		action       <= act;
		new_priority <= pr;
		run_time     <= rt;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		if (act == ACT_TICK)
			ticks_sent++;
		else
			adds_sent++;
		@(negedge clk);
	endtask

	// Random item: ticks at the given percentage. Priorities lean on a narrow
	// band so ties are common, with the extremes and full-range values mixed in.
	// Run times are mostly short so processes finish, a few zero (refused) and
	// a few long ones that sit in the queue and push it toward full.
	task automatic random_item(int tick_pct);
		logic              act;
		logic signed [7:0] pr;
		logic [7:0]        rt;
		int                pick;
		act  = ($urandom_range(0, 99) < tick_pct) ? ACT_TICK : ACT_ADD;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			pr = 8'($signed($urandom_range(0, 4)) - 2);
		else if (pick == 4)
			pr = $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
		else
			pr = 8'($urandom);
		pick = $urandom_range(0, 49);
		if (pick < 2)
			rt = 8'd0;
		else if (pick == 2)
			rt = 8'($urandom);
		else if (pick < 10)
			rt = 8'($urandom_range(5, 30));
		else
			rt = 8'($urandom_range(1, 4));
		send_item(act, pr, rt);
	endtask

	// drop valid and wait until every result has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (awaited != 0)
			@(negedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// ---- directed part ----
		send_item(ACT_TICK, 8'sd0, 8'd0);         // tick on empty queue
		send_item(ACT_ADD, 8'sd0, 8'd0);          // zero run time, refused
		send_item(ACT_ADD, -8'sd128, 8'd2);       // minimum priority
		send_item(ACT_TICK, 8'sd0, 8'd0);         // decrement saturates, requeued
		send_item(ACT_TICK, 8'sd0, 8'd0);         // finishes, queue empty again
		send_item(ACT_ADD, 8'sd127, 8'd255);      // max priority and time
		send_item(ACT_ADD, 8'sd127, 8'd3);        // tie with head lands behind it
		send_item(ACT_ADD, -8'sd1, 8'd1);
		send_item(ACT_ADD, -8'sd1, 8'd8);         // tie further down the list
		send_item(ACT_ADD, 8'sd100, 8'h55);
		send_item(ACT_ADD, -8'sd128, 8'hAA);
		// top up to a full queue
		repeat (QUEUE_DEPTH - 6)
			send_item(ACT_ADD, 8'($urandom), 8'($urandom_range(1, 4)));
		send_item(ACT_ADD, 8'sd5, 8'd7);          // full queue, refused
		send_item(ACT_TICK, 8'sd0, 8'd0);
		send_item(ACT_TICK, 8'sd0, 8'd0);

		// ---- sender 38 / receiver 79 ----
		repeat (200)
			random_item(45);

		// ---- long output hold-off while the sender keeps offering ----
		send_idle_pct = 0;
		hold_request  = 1'b1;
		repeat (30)
			random_item(40);
		// pause the sender until the block has answered everything
		drain();

		// ---- sender 79 / receiver 38 ----
		send_idle_pct = 79;
		recv_idle_pct = 38;
		repeat (150)
			random_item(55);

		// ---- no idling; swing between add-heavy and tick-heavy ----
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (4) begin
			repeat (50)
				random_item(25);
			repeat (50)
				random_item(75);
		end

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Run covered %0d adds and %0d ticks over three idle mixes,",
			adds_sent, ticks_sent);
		$display("a %0d-cycle output hold-off, a drain pause and full/empty queues.",
			HOLD_CYCLES);
		if (mismatches == 0)
			$display("dynamic_priority_process_scheduler verification clean");
		else
			$display("dynamic_priority_process_scheduler verification failed");
		$finish;
	end

	// watchdog, several times the slowest expected run
	initial begin
		#800000;
		$display("dynamic_priority_process_scheduler verification failed");
		$finish;
	end

endmodule
